// ===== hdl/sbrc_pkg.sv =====
// Shared types and codes for the swap buffer rotation controller.
package sbrc_pkg;

	typedef logic [2:0] buf_state_t;

	localparam buf_state_t ST_EMPTY   = 3'd0;
	localparam buf_state_t ST_READING = 3'd1;
	localparam buf_state_t ST_READ    = 3'd2;
	localparam buf_state_t ST_WRITING = 3'd3;
	localparam buf_state_t ST_WRITTEN = 3'd4;

	localparam logic [1:0] CMD_ACQ_READ  = 2'd0;
	localparam logic [1:0] CMD_ACQ_WRITE = 2'd1;
	localparam logic [1:0] CMD_FINISH    = 2'd2;

	localparam logic [1:0] REG_BUFFER_COUNT  = 2'd0;
	localparam logic [1:0] REG_REPEAT_READS  = 2'd1;
	localparam logic [1:0] REG_REPEAT_WRITES = 2'd2;

	localparam int MAX_LEGAL_COUNT = 4;

	typedef struct packed {
		logic       granted;
		logic [1:0] granted_index;
		logic       error;
	} result_t;

	typedef struct packed {
		logic [2:0] buffer_count;
		logic       repeat_reads;
		logic       repeat_writes;
	} config_t;

endpackage

// ===== hdl/sbrc_decide.sv =====
// Combinational decision for one command: next buffer states, positions and result.
module sbrc_decide #(
	parameter int NUM_SLOTS = 4
) (
	input  sbrc_pkg::config_t                        cfg,
	input  logic [1:0]                               cmd,
	input  logic [1:0]                               buffer_index,
	input  sbrc_pkg::buf_state_t [NUM_SLOTS-1:0]     st,
	input  logic [1:0]                               rd_pos,
	input  logic [1:0]                               wr_pos,
	output sbrc_pkg::buf_state_t [NUM_SLOTS-1:0]     st_nxt,
	output logic [1:0]                               rd_pos_nxt,
	output logic [1:0]                               wr_pos_nxt,
	output sbrc_pkg::result_t                        res
);
	import sbrc_pkg::*;

	logic       legal;
	logic [2:0] min_count;
	logic       any_reading;
	logic       any_writing;
	logic [2:0] rd_sum;
	logic [2:0] wr_sum;
	logic [2:0] rd_next;
	logic [2:0] wr_next;
	buf_state_t rd_next_st;
	buf_state_t wr_next_st;
	buf_state_t rd_cur_st;
	buf_state_t wr_cur_st;
	buf_state_t fin_st;

	// (pos + 1) mod count; pos may sit above a count lowered later, so two folds
	always_comb begin
		rd_sum = {1'b0, rd_pos} + 3'd1;
		wr_sum = {1'b0, wr_pos} + 3'd1;
		rd_next = rd_sum;
		if (rd_next >= cfg.buffer_count) rd_next = rd_next - cfg.buffer_count;
		if (rd_next >= cfg.buffer_count) rd_next = rd_next - cfg.buffer_count;
		wr_next = wr_sum;
		if (wr_next >= cfg.buffer_count) wr_next = wr_next - cfg.buffer_count;
		if (wr_next >= cfg.buffer_count) wr_next = wr_next - cfg.buffer_count;
	end

	always_comb begin
		min_count = 3'd1 + {2'b00, cfg.repeat_reads} + {2'b00, cfg.repeat_writes};
		legal = (cfg.buffer_count >= 3'd2) && (cfg.buffer_count <= 3'(MAX_LEGAL_COUNT))
			&& (cfg.buffer_count <= 3'(NUM_SLOTS)) && (cfg.buffer_count > min_count);
	end

	// slot lookups by decode; an index with no slot reads as empty
	always_comb begin
		any_reading = 1'b0;
		any_writing = 1'b0;
		rd_next_st  = ST_EMPTY;
		wr_next_st  = ST_EMPTY;
		rd_cur_st   = ST_EMPTY;
		wr_cur_st   = ST_EMPTY;
		fin_st      = ST_EMPTY;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (3'(k) < cfg.buffer_count) begin
				if (st[k] == ST_READING) any_reading = 1'b1;
				if (st[k] == ST_WRITING) any_writing = 1'b1;
			end
			if (rd_next == 3'(k))      rd_next_st = st[k];
			if (wr_next == 3'(k))      wr_next_st = st[k];
			if (rd_pos == 2'(k))       rd_cur_st  = st[k];
			if (wr_pos == 2'(k))       wr_cur_st  = st[k];
			if (buffer_index == 2'(k)) fin_st     = st[k];
		end
	end

	always_comb begin
		st_nxt     = st;
		rd_pos_nxt = rd_pos;
		wr_pos_nxt = wr_pos;
		res        = '0;
		if (!legal) begin
			res.error = (cmd == CMD_ACQ_READ) || (cmd == CMD_ACQ_WRITE) || (cmd == CMD_FINISH);
		end else begin
			case (cmd)
				CMD_ACQ_READ: begin
					if (any_reading) begin
						res.error = 1'b1;
					end else if (rd_next_st == ST_WRITTEN &&
						(!cfg.repeat_reads || rd_next[1:0] != wr_pos)) begin
						rd_pos_nxt = rd_next[1:0];
						for (int k = 0; k < NUM_SLOTS; k++)
							if (rd_next == 3'(k)) st_nxt[k] = ST_READING;
						res.granted       = 1'b1;
						res.granted_index = rd_next[1:0];
					end else if (cfg.repeat_reads && rd_cur_st == ST_READ) begin
						for (int k = 0; k < NUM_SLOTS; k++)
							if (rd_pos == 2'(k)) st_nxt[k] = ST_READING;
						res.granted       = 1'b1;
						res.granted_index = rd_pos;
					end
				end
				CMD_ACQ_WRITE: begin
					if (any_writing) begin
						res.error = 1'b1;
					end else if (wr_next_st == ST_EMPTY || (wr_next_st == ST_READ &&
						(!cfg.repeat_writes || wr_next[1:0] != rd_pos))) begin
						wr_pos_nxt = wr_next[1:0];
						for (int k = 0; k < NUM_SLOTS; k++)
							if (wr_next == 3'(k)) st_nxt[k] = ST_WRITING;
						res.granted       = 1'b1;
						res.granted_index = wr_next[1:0];
					end else if (cfg.repeat_writes && wr_cur_st == ST_WRITTEN) begin
						for (int k = 0; k < NUM_SLOTS; k++)
							if (wr_pos == 2'(k)) st_nxt[k] = ST_WRITING;
						res.granted       = 1'b1;
						res.granted_index = wr_pos;
					end
				end
				CMD_FINISH: begin
					if (fin_st == ST_READING || fin_st == ST_WRITING) begin
						for (int k = 0; k < NUM_SLOTS; k++)
							if (buffer_index == 2'(k))
								st_nxt[k] = (fin_st == ST_READING) ? ST_READ : ST_WRITTEN;
					end else begin
						res.error = 1'b1;
					end
				end
				default: res = '0;
			endcase
		end
	end

endmodule

// ===== hdl/swap_buffer_rotation_controller_top.sv =====
// Top level of the swap buffer rotation controller.
//
// Hands 2 to 4 rotating buffers to one producer and one consumer.
// Command channel (in_valid/in_ready): cmd is acquire-read, acquire-write
// or finish; buffer_index names the buffer a finish releases.
// Result channel (out_valid/out_ready): one beat per command, carrying
// granted, granted_index and error.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects
// buffer_count, repeat_reads or repeat_writes; other indexes are dropped.
// Write it only while no command is in flight.
// Path: a command beat lands in the input register, the decision is
// made combinationally from it, and the result register captures it
// once it is free or being read. Throughput: one command per cycle
// unless out_ready stalls; the buffer-state update is a single
// decision between the input register and the result register.
// Reset: all buffers empty, both positions 0, buffer_count 3, repeat
// modes off. No clearing pass is needed.
// Receiver stall: the result register holds; the input register keeps one
// more command, then in_ready drops until out_ready returns.
module swap_buffer_rotation_controller_top #(
	parameter int MAX_BUFFERS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [1:0] buffer_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       granted,
	output logic [1:0] granted_index,
	output logic       error,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [2:0] cfg_data
);
	import sbrc_pkg::*;

	// only slots below 4 are ever reachable: count tops out at 4
	localparam int NUM_SLOTS = (MAX_BUFFERS < MAX_LEGAL_COUNT) ? MAX_BUFFERS : MAX_LEGAL_COUNT;

	config_t                     cfg_q;
	buf_state_t [NUM_SLOTS-1:0]  st_q;
	buf_state_t [NUM_SLOTS-1:0]  st_nxt;
	logic [1:0]                  rd_pos_q, wr_pos_q;
	logic [1:0]                  rd_pos_nxt, wr_pos_nxt;

	// input register
	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [1:0] idx_s1;

	// result register
	logic    out_valid_q;
	result_t res_q;
	result_t res;

	logic advance_s1;

	assign cfg_ready  = 1'b1;
	assign advance_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_count  <= 3'd3;
			cfg_q.repeat_reads  <= 1'b0;
			cfg_q.repeat_writes <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BUFFER_COUNT:  cfg_q.buffer_count  <= cfg_data;
				REG_REPEAT_READS:  cfg_q.repeat_reads  <= cfg_data[0];
				REG_REPEAT_WRITES: cfg_q.repeat_writes <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
			idx_s1 <= buffer_index;
		end
	end

	sbrc_decide #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_decide (
		.cfg          (cfg_q),
		.cmd          (cmd_s1),
		.buffer_index (idx_s1),
		.st           (st_q),
		.rd_pos       (rd_pos_q),
		.wr_pos       (wr_pos_q),
		.st_nxt       (st_nxt),
		.rd_pos_nxt   (rd_pos_nxt),
		.wr_pos_nxt   (wr_pos_nxt),
		.res          (res)
	);

	// buffer state commits as the command moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '{default: ST_EMPTY};
			rd_pos_q <= 2'd0;
			wr_pos_q <= 2'd0;
		end else if (advance_s1) begin
			st_q     <= st_nxt;
			rd_pos_q <= rd_pos_nxt;
			wr_pos_q <= wr_pos_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) res_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign granted       = res_q.granted;
	assign granted_index = res_q.granted_index;
	assign error         = res_q.error;

endmodule

// ===== bench/swap_buffer_rotation_controller_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the swap buffer rotation controller: directed table, then random.
module swap_buffer_rotation_controller_top_tb;
	import sbrc_pkg::*;

	// Bench-side constants. Command 3 has no name in the package.
	localparam int         NUM_BUFS         = 4;
	localparam logic [1:0] CMD_UNUSED       = 2'd3;
	localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;
	localparam int         HOLD_CYCLES      = 300;  // one long receiver hold-off
	localparam int         STUCK_LIMIT      = 2000; // cycles with no beat on any channel
	localparam int         TAIL_CYCLES      = 8;    // margin after the last result
	localparam int         MAX_PRINTED      = 40;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_ready;
	logic [1:0] cmd           = 2'd0;
	logic [1:0] buffer_index  = 2'd0;
	logic       out_valid;
	logic       out_ready     = 1'b0;
	logic       granted;
	logic [1:0] granted_index;
	logic       error;
	logic       cfg_valid     = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index     = 2'd0;
	logic [2:0] cfg_data      = 3'd0;

	swap_buffer_rotation_controller_top #(
		.MAX_BUFFERS(NUM_BUFS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.buffer_index (buffer_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.granted      (granted),
		.granted_index(granted_index),
		.error        (error),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 4 ns period.
	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow copy of the controller: buffer states, positions, registers.
	// ------------------------------------------------------------------
	buf_state_t buf_st [NUM_BUFS];
	logic [1:0] rd_pos;
	logic [1:0] wr_pos;
	config_t    mode;

	// Grants expected on the result channel, oldest first.
	result_t    pending_results [$];

	int  mismatch_count = 0;
	int  result_beats   = 0;
	int  stuck_cycles   = 0;
	int  tx_calm        = 0;
	int  rx_calm        = 0;
	bit  hold_off_req   = 1'b0;
	bit  hold_off_done  = 1'b0;
	result_t oldest;

	task automatic clear_shadow();
		for (int k = 0; k < NUM_BUFS; k++)
			buf_st[k] = ST_EMPTY;
		rd_pos = 2'd0;
		wr_pos = 2'd0;
		mode.buffer_count  = 3'd3;
		mode.repeat_reads  = 1'b0;
		mode.repeat_writes = 1'b0;
	endtask

	// Count must be 2..4 and leave room for each enabled repeat mode plus one spare.
	function automatic bit mode_legal();
		int cnt;
		cnt = int'(mode.buffer_count);
		if (cnt < 2 || cnt > MAX_LEGAL_COUNT || cnt > NUM_BUFS)
			return 1'b0;
		return cnt > 1 + int'(mode.repeat_reads) + int'(mode.repeat_writes);
	endfunction

	// Only buffers in rotation count when looking for a second acquire.
	function automatic bit holds_state(input buf_state_t st);
		for (int k = 0; k < int'(mode.buffer_count) && k < NUM_BUFS; k++)
			if (buf_st[k] == st)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [1:0] next_slot(input logic [1:0] pos);
		return 2'((int'(pos) + 1) % int'(mode.buffer_count));
	endfunction

	// Decides one command against the shadow state and updates it.
	function automatic result_t decide_request(input logic [1:0] c, input logic [1:0] bi);
		result_t    res;
		logic [1:0] nx;
		res = '0;
		if (!mode_legal()) begin
			res.error = (c != CMD_UNUSED);
		end else begin
			case (c)
				CMD_ACQ_READ: begin
					if (holds_state(ST_READING)) begin
						res.error = 1'b1;
					end else begin
						nx = next_slot(rd_pos);
						if (buf_st[nx] == ST_WRITTEN &&
						    (!mode.repeat_reads || nx != wr_pos)) begin
							rd_pos = nx;
							buf_st[nx] = ST_READING;
							res.granted = 1'b1;
							res.granted_index = nx;
						end else if (mode.repeat_reads && buf_st[rd_pos] == ST_READ) begin
							buf_st[rd_pos] = ST_READING;
							res.granted = 1'b1;
							res.granted_index = rd_pos;
						end
					end
				end
				CMD_ACQ_WRITE: begin
					if (holds_state(ST_WRITING)) begin
						res.error = 1'b1;
					end else begin
						nx = next_slot(wr_pos);
						if (buf_st[nx] == ST_EMPTY ||
						    (buf_st[nx] == ST_READ &&
						     (!mode.repeat_writes || nx != rd_pos))) begin
							wr_pos = nx;
							buf_st[nx] = ST_WRITING;
							res.granted = 1'b1;
							res.granted_index = nx;
						end else if (mode.repeat_writes &&
						             buf_st[wr_pos] == ST_WRITTEN) begin
							buf_st[wr_pos] = ST_WRITING;
							res.granted = 1'b1;
							res.granted_index = wr_pos;
						end
					end
				end
				CMD_FINISH: begin
					if (int'(bi) >= NUM_BUFS)
						res.error = 1'b1;
					else if (buf_st[bi] == ST_READING)
						buf_st[bi] = ST_READ;
					else if (buf_st[bi] == ST_WRITING)
						buf_st[bi] = ST_WRITTEN;
					else
						res.error = 1'b1;
				end
				default: ;
			endcase
		end
		return res;
	endfunction

	// Mostly short gaps, a few long ones, and now and then a calm run with none.
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Protocol-aware pick: acquire when the side is free, finish what is held.
	// About one command in seven is raw noise.
	function automatic void pick_command(output logic [1:0] c, output logic [1:0] bi);
		logic [1:0] opt_cmd [$];
		logic [1:0] opt_idx [$];
		int         sel;
		c  = 2'($urandom_range(0, 3));
		bi = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < 15)
			return;
		if (!holds_state(ST_READING)) begin
			opt_cmd.push_back(CMD_ACQ_READ);
			opt_idx.push_back(bi);
		end
		if (!holds_state(ST_WRITING)) begin
			opt_cmd.push_back(CMD_ACQ_WRITE);
			opt_idx.push_back(bi);
		end
		for (int k = 0; k < NUM_BUFS; k++) begin
			if (buf_st[k] == ST_READING || buf_st[k] == ST_WRITING) begin
				opt_cmd.push_back(CMD_FINISH);
				opt_idx.push_back(2'(k));
			end
		end
		if (opt_cmd.size() == 0)
			return;
		sel = $urandom_range(0, opt_cmd.size() - 1);
		c  = opt_cmd[sel];
		bi = opt_idx[sel];
	endfunction

	task automatic note_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTED)
			$display("[%0t] MISMATCH %s", $time, msg);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// Sender side. Drive at negedge, detect acceptance at posedge.
	// ------------------------------------------------------------------
	task automatic offer_command(input logic [1:0] c, input logic [1:0] bi,
		input bit typed, input result_t typed_exp);
		result_t model_exp;
		@(negedge clk);
		in_valid     <= 1'b1;
		cmd          <= c;
		buffer_index <= bi;
		do @(posedge clk); while (!in_ready);
		// Shadow state always advances; a typed row overrides what is expected.
		model_exp = decide_request(c, bi);
		pending_results.push_back(typed ? typed_exp : model_exp);
	endtask

	task automatic sender_gap(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [2:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_BUFFER_COUNT:  mode.buffer_count  = data;
			REG_REPEAT_READS:  mode.repeat_reads  = data[0];
			REG_REPEAT_WRITES: mode.repeat_writes = data[0];
			default: ; // dropped by the block
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Directed table, run with the reset configuration (3 buffers, no
	// repeat modes). Rows 1-16 have their answer typed in; the tail rows
	// are left to the shadow model.
	// ------------------------------------------------------------------
	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] idx;
		logic       typed;
		logic       granted;
		logic [1:0] granted_index;
		logic       error;
	} dir_row_t;

	localparam int DIR_ROWS = 22;

	dir_row_t directed_rows [DIR_ROWS] = '{
		'{CMD_FINISH,    2'd0, 1'b1, 1'b0, 2'd0, 1'b1}, // finish of an empty buffer
		'{CMD_ACQ_READ,  2'd0, 1'b1, 1'b0, 2'd0, 1'b0}, // nothing written yet
		'{CMD_ACQ_WRITE, 2'd0, 1'b1, 1'b1, 2'd1, 1'b0}, // first write lands on 1
		'{CMD_ACQ_WRITE, 2'd0, 1'b1, 1'b0, 2'd0, 1'b1}, // second acquire while writing
		'{CMD_FINISH,    2'd1, 1'b1, 1'b0, 2'd0, 1'b0},
		'{CMD_ACQ_READ,  2'd2, 1'b1, 1'b1, 2'd1, 1'b0}, // index ignored on acquire
		'{CMD_ACQ_READ,  2'd0, 1'b1, 1'b0, 2'd0, 1'b1}, // second acquire while reading
		'{CMD_FINISH,    2'd3, 1'b1, 1'b0, 2'd0, 1'b1}, // top index, outside rotation
		'{CMD_UNUSED,    2'd3, 1'b1, 1'b0, 2'd0, 1'b0}, // unused command
		'{CMD_FINISH,    2'd1, 1'b1, 1'b0, 2'd0, 1'b0},
		'{CMD_ACQ_WRITE, 2'd0, 1'b1, 1'b1, 2'd2, 1'b0},
		'{CMD_FINISH,    2'd2, 1'b1, 1'b0, 2'd0, 1'b0},
		'{CMD_ACQ_WRITE, 2'd0, 1'b1, 1'b1, 2'd0, 1'b0}, // wrap to 0
		'{CMD_FINISH,    2'd0, 1'b1, 1'b0, 2'd0, 1'b0},
		'{CMD_ACQ_WRITE, 2'd1, 1'b1, 1'b1, 2'd1, 1'b0}, // reuse an already read buffer
		'{CMD_FINISH,    2'd1, 1'b1, 1'b0, 2'd0, 1'b0},
		'{CMD_ACQ_WRITE, 2'd0, 1'b0, 1'b0, 2'd0, 1'b0}, // all written: writer starves
		'{CMD_ACQ_READ,  2'd0, 1'b0, 1'b0, 2'd0, 1'b0},
		'{CMD_FINISH,    2'd2, 1'b0, 1'b0, 2'd0, 1'b0},
		'{CMD_FINISH,    2'd2, 1'b0, 1'b0, 2'd0, 1'b0}, // finish twice
		'{CMD_ACQ_WRITE, 2'd3, 1'b0, 1'b0, 2'd0, 1'b0},
		'{CMD_FINISH,    2'd2, 1'b0, 1'b0, 2'd0, 1'b0}
	};

	// Register settings for the random part, legal extremes first, then the
	// illegal ones (every command but the unused one answers error), then back to legal.
	typedef struct {
		logic [2:0] count;
		logic       rep_rd;
		logic       rep_wr;
		int         items;
	} phase_t;

	localparam int NUM_PHASES = 15;

	phase_t phases [NUM_PHASES] = '{
		'{3'd3, 1'b0, 1'b0, 60},
		'{3'd2, 1'b0, 1'b0, 70},
		'{3'd4, 1'b0, 1'b0, 70},
		'{3'd4, 1'b1, 1'b1, 90}, // receiver hold-off runs here
		'{3'd3, 1'b1, 1'b0, 80},
		'{3'd3, 1'b0, 1'b1, 80},
		'{3'd4, 1'b1, 1'b0, 60},
		'{3'd2, 1'b1, 1'b0, 15}, // too few buffers for a repeat mode
		'{3'd0, 1'b0, 1'b0, 10},
		'{3'd7, 1'b1, 1'b1, 10},
		'{3'd5, 1'b0, 1'b0, 10},
		'{3'd1, 1'b0, 1'b0, 10},
		'{3'd3, 1'b1, 1'b1, 15}, // both repeat modes need four
		'{3'd4, 1'b0, 1'b1, 70},
		'{3'd2, 1'b0, 1'b0, 50}
	};

	initial begin : stimulus
		logic [1:0] c;
		logic [1:0] bi;
		result_t    typed_exp;
		clear_shadow();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < DIR_ROWS; k++) begin
			typed_exp.granted       = directed_rows[k].granted;
			typed_exp.granted_index = directed_rows[k].granted_index;
			typed_exp.error         = directed_rows[k].error;
			offer_command(directed_rows[k].cmd, directed_rows[k].idx,
				directed_rows[k].typed, typed_exp);
			sender_gap(pick_gap(tx_calm));
		end
		@(negedge clk);
		in_valid <= 1'b0;

		for (int p = 0; p < NUM_PHASES; p++) begin
			// Registers change only with nothing in flight.
			wait_drained();
			if (p == 1)
				write_reg(CFG_UNUSED_INDEX, 3'd7);
			write_reg(REG_BUFFER_COUNT, phases[p].count);
			write_reg(REG_REPEAT_READS, {2'b00, phases[p].rep_rd});
			write_reg(REG_REPEAT_WRITES, {2'b00, phases[p].rep_wr});
			if (p == 3)
				hold_off_req = 1'b1;
			for (int k = 0; k < phases[p].items; k++) begin
				pick_command(c, bi);
				offer_command(c, bi, 1'b0, '0);
				sender_gap(pick_gap(tx_calm));
			end
			@(negedge clk);
			in_valid <= 1'b0;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off so the input register
	// fills and in_ready drops while the sender keeps offering beats.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_off_done) begin
				hold_off_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready <= 1'b1;
			n = pick_gap(rx_calm);
			if (n > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	// Each result beat against the oldest pending expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			result_beats++;
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("beat %0d arrived with nothing pending", result_beats));
			end else begin
				oldest = pending_results.pop_front();
				if (granted !== oldest.granted)
					note_mismatch($sformatf("beat %0d granted: got %b, want %b",
						result_beats, granted, oldest.granted));
				if (granted_index !== oldest.granted_index)
					note_mismatch($sformatf("beat %0d granted_index: got %0d, want %0d",
						result_beats, granted_index, oldest.granted_index));
				if (error !== oldest.error)
					note_mismatch($sformatf("beat %0d error: got %b, want %b",
						result_beats, error, oldest.error));
			end
		end
	end

	// Watchdog: any beat on any channel counts as progress.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("[%0t] watchdog: no beat for %0d cycles", $time, STUCK_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule

// ===== files.f =====
hdl/sbrc_pkg.sv
hdl/sbrc_decide.sv
hdl/swap_buffer_rotation_controller_top.sv
bench/swap_buffer_rotation_controller_top_tb.sv
